>>> hw/rtl/assert_macros.svh
// Shared assertion wrappers. Every user module has clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/dwgs_pkg.sv
package dwgs_pkg;

  // Request codes on req_type. Code 3 is unused and answers like a sweep with no work.
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_SWEEP = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_COUPLING  = 3'd0;
  localparam logic [2:0] CFG_DAMPING   = 3'd1;
  localparam logic [2:0] CFG_GRID_SIZE = 3'd2;
  localparam logic [2:0] CFG_BARRIER   = 3'd3;
  localparam logic [2:0] CFG_BAR_ROW   = 3'd4;
  localparam logic [2:0] CFG_SLIT_LOW  = 3'd5;
  localparam logic [2:0] CFG_SLIT_HIGH = 3'd6;

  typedef struct packed {
    logic [15:0] coupling_gain;
    logic [15:0] damping_gain;
    logic        barrier_enable;
    logic [7:0]  barrier_row;
    logic [7:0]  slit_low;
    logic [7:0]  slit_high;
  } sweep_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sweep_status_t;

endpackage

>>> hw/rtl/dwgs_mem.sv
module dwgs_mem #(
  parameter int MAX_GRID   = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic                                      clk,
  input  logic                                      h_we,
  input  logic                                      v_we,
  input  logic [$clog2(MAX_GRID*MAX_GRID)-1:0]      wr_addr,
  input  logic signed [VALUE_BITS-1:0]              h_wdata,
  input  logic signed [VALUE_BITS-1:0]              v_wdata,
  input  logic [$clog2(MAX_GRID*MAX_GRID)-1:0]      h_rd_addr,
  input  logic [$clog2(MAX_GRID*MAX_GRID)-1:0]      v_rd_addr,
  output logic signed [VALUE_BITS-1:0]              h_rdata,
  output logic signed [VALUE_BITS-1:0]              v_rdata
);

  localparam int DEPTH = MAX_GRID * MAX_GRID;

  logic signed [VALUE_BITS-1:0] height_store   [DEPTH];
  logic signed [VALUE_BITS-1:0] velocity_store [DEPTH];

  always_ff @(posedge clk) begin
    if (h_we) begin
      height_store[wr_addr] <= h_wdata;
    end
    h_rdata <= height_store[h_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      velocity_store[wr_addr] <= v_wdata;
    end
    v_rdata <= velocity_store[v_rd_addr];
  end

endmodule

>>> hw/rtl/dwgs_sweep.sv
module dwgs_sweep
  import dwgs_pkg::*;
#(
  parameter int MAX_GRID   = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  input  logic [8:0]                                n,
  input  sweep_cfg_t                                cfg,
  output sweep_status_t                             status,
  output logic [$clog2(MAX_GRID*MAX_GRID)-1:0]      h_rd_addr,
  output logic [$clog2(MAX_GRID*MAX_GRID)-1:0]      v_rd_addr,
  input  logic signed [VALUE_BITS-1:0]              h_rdata,
  input  logic signed [VALUE_BITS-1:0]              v_rdata,
  output logic                                      h_we,
  output logic                                      v_we,
  output logic [$clog2(MAX_GRID*MAX_GRID)-1:0]      wr_addr,
  output logic signed [VALUE_BITS-1:0]              h_wdata,
  output logic signed [VALUE_BITS-1:0]              v_wdata
);

  `include "assert_macros.svh"

  localparam int VB   = VALUE_BITS;
  localparam int AW   = $clog2(MAX_GRID * MAX_GRID);
  localparam int CW   = $clog2(MAX_GRID);
  localparam int CMPW = (CW > 9) ? CW : 9;

  localparam logic [AW-1:0] ROW_STEP = AW'(MAX_GRID);
  localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
  localparam logic signed [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_RD_LEFT = 12'b0000_0000_0010,
    S_RD_CTR  = 12'b0000_0000_0100,
    S_RD_UP   = 12'b0000_0000_1000,
    S_RD_DN   = 12'b0000_0001_0000,
    S_RD_RT   = 12'b0000_0010_0000,
    S_ROW_GO  = 12'b0000_0100_0000,
    S_MEAN    = 12'b0000_1000_0000,
    S_MUL1    = 12'b0001_0000_0000,
    S_VEL     = 12'b0010_0000_0000,
    S_MUL2    = 12'b0100_0000_0000,
    S_UPD     = 12'b1000_0000_0000
  } state_t;

  state_t st;

  logic [CW-1:0]        x, y;
  logic [AW-1:0]        ca;
  logic signed [VB-1:0] hc, rt, left, vel_c, v1;
  logic signed [VB+2:0] acc, acc_n;
  logic signed [VB:0]   diff;
  logic signed [VB+17:0] p1;
  logic signed [VB+16:0] p2;
  logic                 done;

  logic signed [VB+2:0]  quad_sum, vsum, hsum;
  logic signed [VB+17:0] p1_next;
  logic signed [VB+16:0] p2_next;
  logic signed [VB-1:0]  v1_next, v2, hn_val;
  logic                  x_last, y_last, frozen;

  function automatic logic signed [VB-1:0] sat_val(input logic signed [VB+2:0] v);
    if ((&v[VB+2:VB-1]) || !(|v[VB+2:VB-1])) begin
      return v[VB-1:0];
    end else if (v[VB+2]) begin
      return VMIN;
    end else begin
      return VMAX;
    end
  endfunction

  function automatic logic signed [VB+2:0] neg4(input logic signed [VB-1:0] v);
    return -((VB+3)'(v) <<< 2);
  endfunction

  // Left neighbor joins last, so the loop through the freshly updated left cell
  // is one add, two multiplies and two saturating adds.
  assign quad_sum = acc + (VB+3)'(left);
  assign p1_next  = (VB+18)'(diff) * (VB+18)'($signed({1'b0, cfg.coupling_gain}));
  assign vsum     = (VB+3)'(vel_c) + (VB+3)'($signed(p1[VB+17:16]));
  assign v1_next  = sat_val(vsum);
  assign p2_next  = (VB+17)'(v1) * (VB+17)'($signed({1'b0, cfg.damping_gain}));
  // A gain below one cannot push the damped velocity out of range.
  assign v2       = $signed(p2[VB+15:16]);
  assign hsum     = (VB+3)'(hc) + (VB+3)'(v2);
  assign hn_val   = sat_val(hsum);

  assign x_last = (CMPW'(x) == CMPW'(n) - CMPW'(2));
  assign y_last = (CMPW'(y) == CMPW'(n) - CMPW'(2));
  assign frozen = cfg.barrier_enable && (CMPW'(y) == CMPW'(cfg.barrier_row)) &&
                  ((CMPW'(x) < CMPW'(cfg.slit_low)) || (CMPW'(x) > CMPW'(cfg.slit_high)));

  always_comb begin
    h_rd_addr = ca;
    v_rd_addr = ca;
    unique case (st)
      S_RD_LEFT: h_rd_addr = ca - AW'(1);
      S_RD_CTR:  h_rd_addr = ca;
      S_RD_UP:   h_rd_addr = ca - ROW_STEP;
      S_RD_DN:   h_rd_addr = ca + ROW_STEP;
      S_RD_RT:   h_rd_addr = ca + AW'(1);
      S_MUL1:    h_rd_addr = ca + AW'(1) - ROW_STEP;
      S_VEL:     h_rd_addr = ca + AW'(1) + ROW_STEP;
      S_MUL2: begin
        h_rd_addr = ca + AW'(2);
        v_rd_addr = ca + AW'(1);
      end
      default: begin
        h_rd_addr = ca;
        v_rd_addr = ca;
      end
    endcase
  end

  assign h_we    = (st == S_UPD) && !frozen;
  assign v_we    = (st == S_UPD);
  assign wr_addr = ca;
  assign h_wdata = hn_val;
  assign v_wdata = v2;

  assign status.busy = (st != S_IDLE);
  assign status.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= (st == S_IDLE && start && n < 9'd3) || (st == S_UPD && x_last && y_last);
      unique case (st)
        S_IDLE: begin
          if (start && n >= 9'd3) begin
            st <= S_RD_LEFT;
          end
        end
        S_RD_LEFT: st <= S_RD_CTR;
        S_RD_CTR:  st <= S_RD_UP;
        S_RD_UP:   st <= S_RD_DN;
        S_RD_DN:   st <= S_RD_RT;
        S_RD_RT:   st <= S_ROW_GO;
        S_ROW_GO:  st <= S_MEAN;
        S_MEAN:    st <= S_MUL1;
        S_MUL1:    st <= S_VEL;
        S_VEL:     st <= S_MUL2;
        S_MUL2:    st <= S_UPD;
        S_UPD: begin
          if (!x_last) begin
            st <= S_MEAN;
          end else if (!y_last) begin
            st <= S_RD_LEFT;
          end else begin
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // Datapath and position counters.
  always_ff @(posedge clk) begin
    unique case (st)
      S_IDLE: begin
        x  <= CW'(1);
        y  <= CW'(1);
        ca <= ROW_STEP + AW'(1);
      end
      S_RD_CTR: left <= h_rdata;
      S_RD_UP: begin
        hc  <= h_rdata;
        acc <= neg4(h_rdata);
      end
      S_RD_DN: acc <= acc + (VB+3)'(h_rdata);
      S_RD_RT: acc <= acc + (VB+3)'(h_rdata);
      S_ROW_GO: begin
        acc   <= acc + (VB+3)'(h_rdata);
        rt    <= h_rdata;
        vel_c <= v_rdata;
      end
      S_MEAN: diff <= quad_sum[VB+2:2];
      S_MUL1: begin
        p1    <= p1_next;
        acc_n <= neg4(rt);
      end
      S_VEL: begin
        v1    <= v1_next;
        acc_n <= acc_n + (VB+3)'(h_rdata);
      end
      S_MUL2: begin
        p2    <= p2_next;
        acc_n <= acc_n + (VB+3)'(h_rdata);
      end
      S_UPD: begin
        // Load the next cell of the row; a row change reloads all of this.
        acc   <= acc_n + (VB+3)'(h_rdata);
        rt    <= h_rdata;
        hc    <= rt;
        vel_c <= v_rdata;
        left  <= frozen ? hc : hn_val;
        if (!x_last) begin
          x  <= x + CW'(1);
          ca <= ca + AW'(1);
        end else begin
          x  <= CW'(1);
          y  <= y + CW'(1);
          ca <= ca + ROW_STEP - AW'(n) + AW'(3);
        end
      end
      default: begin
        x <= x;
      end
    endcase
  end

  `ASSERT_IMPL(a_start_when_idle, start, st == S_IDLE, "sweep started while busy")
  `ASSERT_IMPL(a_write_in_update, h_we || v_we, st == S_UPD, "cell write outside update")
  `ASSERT_NEXT(a_done_then_idle, st == S_UPD && x_last && y_last,
               status.done && !status.busy, "last cell did not end the sweep")

endmodule

>>> hw/rtl/damped_wave_grid_sweep_unit.sv
// A write, an out-of-range access or an unused request code answers in the cycle after
//   acceptance; an in-range read first passes the registered memory read in state S_READ.
// An n by n sweep answers when its last interior cell is updated, or for n < 3 when
//   the sweep reports done without work. Each interior cell runs S_MEAN to S_UPD, the
//   update loop via the left neighbor; S_RD_LEFT to S_ROW_GO load each row's first cell.
// One request is handled at a time; the next is taken once the result register frees.
// Synchronous reset restores the register defaults; the cell stores are not cleared.
module damped_wave_grid_sweep_unit
  import dwgs_pkg::*;
#(
  parameter int MAX_GRID   = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         req_type,
  input  logic [7:0]         row,
  input  logic [7:0]         col,
  input  logic signed [31:0] height_in,
  input  logic signed [31:0] velocity_in,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic signed [31:0] height_out,
  output logic signed [31:0] velocity_out,
  output logic               status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  `include "assert_macros.svh"

  localparam int VB = VALUE_BITS;
  localparam int AW = $clog2(MAX_GRID * MAX_GRID);
  localparam logic [AW-1:0] ROW_STEP = AW'(MAX_GRID);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_READ  = 3'b010,
    S_SWEEP = 3'b100
  } state_t;

  state_t st;

  logic [15:0] coupling_gain, damping_gain;
  logic [8:0]  grid_size;
  logic        barrier_enable;
  logic [7:0]  barrier_row, slit_low, slit_high;

  logic [8:0]    n;
  logic          in_grid, req_fire, rsp_free, sweeping, rsp_set;
  logic [AW-1:0] req_addr;
  sweep_cfg_t    swp_cfg;
  sweep_status_t swp_stat;

  logic [AW-1:0]        sw_h_rd, sw_v_rd, sw_wr_addr;
  logic                 sw_h_we, sw_v_we;
  logic signed [VB-1:0] sw_h_wdata, sw_v_wdata;

  logic [AW-1:0]        h_rd_addr, v_rd_addr, wr_addr;
  logic                 h_we, v_we;
  logic signed [VB-1:0] h_wdata, v_wdata, h_rdata, v_rdata;

  function automatic logic signed [VB-1:0] to_value(input logic signed [31:0] d);
    logic signed [63:0] e;
    e = 64'(d);
    if ((&e[63:VB-1]) || !(|e[63:VB-1])) begin
      return e[VB-1:0];
    end else if (e[63]) begin
      return {1'b1, {(VB-1){1'b0}}};
    end else begin
      return {1'b0, {(VB-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [31:0] to_port(input logic signed [VB-1:0] d);
    logic signed [63:0] e;
    e = 64'(d);
    return e[31:0];
  endfunction

  assign n        = (grid_size > MAX_GRID) ? 9'(MAX_GRID) : grid_size;
  assign in_grid  = ({1'b0, row} < n) && ({1'b0, col} < n);
  assign req_addr = AW'(row) * ROW_STEP + AW'(col);
  assign rsp_free = !rsp_valid || !rsp_stall;
  assign req_stall = (st != S_IDLE) || !rsp_free;
  assign req_fire = req_valid && !req_stall;
  assign sweeping = (st == S_SWEEP);
  assign cfg_ready = 1'b1;

  // A result beat is loaded for a request that answers at once, a finished read or a
  // finished sweep.
  assign rsp_set = (st == S_IDLE && req_fire && !(req_type == REQ_READ && in_grid) &&
                    req_type != REQ_SWEEP) ||
                   (st == S_READ) || (sweeping && swp_stat.done);

  assign swp_cfg = '{
    coupling_gain:  coupling_gain,
    damping_gain:   damping_gain,
    barrier_enable: barrier_enable,
    barrier_row:    barrier_row,
    slit_low:       slit_low,
    slit_high:      slit_high
  };

  // The sweep owns the stores while it runs; otherwise the request path does.
  assign h_rd_addr = sweeping ? sw_h_rd : req_addr;
  assign v_rd_addr = sweeping ? sw_v_rd : req_addr;
  assign wr_addr   = sweeping ? sw_wr_addr : req_addr;
  assign h_wdata   = sweeping ? sw_h_wdata : to_value(height_in);
  assign v_wdata   = sweeping ? sw_v_wdata : to_value(velocity_in);
  assign h_we      = sweeping ? sw_h_we : (req_fire && req_type == REQ_WRITE && in_grid);
  assign v_we      = sweeping ? sw_v_we : (req_fire && req_type == REQ_WRITE && in_grid);

  dwgs_mem #(
    .MAX_GRID   (MAX_GRID),
    .VALUE_BITS (VALUE_BITS)
  ) u_mem (
    .clk       (clk),
    .h_we      (h_we),
    .v_we      (v_we),
    .wr_addr   (wr_addr),
    .h_wdata   (h_wdata),
    .v_wdata   (v_wdata),
    .h_rd_addr (h_rd_addr),
    .v_rd_addr (v_rd_addr),
    .h_rdata   (h_rdata),
    .v_rdata   (v_rdata)
  );

  dwgs_sweep #(
    .MAX_GRID   (MAX_GRID),
    .VALUE_BITS (VALUE_BITS)
  ) u_sweep (
    .clk       (clk),
    .rst       (rst),
    .start     (req_fire && req_type == REQ_SWEEP),
    .n         (n),
    .cfg       (swp_cfg),
    .status    (swp_stat),
    .h_rd_addr (sw_h_rd),
    .v_rd_addr (sw_v_rd),
    .h_rdata   (h_rdata),
    .v_rdata   (v_rdata),
    .h_we      (sw_h_we),
    .v_we      (sw_v_we),
    .wr_addr   (sw_wr_addr),
    .h_wdata   (sw_h_wdata),
    .v_wdata   (sw_v_wdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      coupling_gain  <= 16'd13107;
      damping_gain   <= 16'd59710;
      grid_size      <= 9'd256;
      barrier_enable <= 1'b1;
      barrier_row    <= 8'd100;
      slit_low       <= 8'd100;
      slit_high      <= 8'd110;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_COUPLING:  coupling_gain  <= cfg_data;
        CFG_DAMPING:   damping_gain   <= cfg_data;
        CFG_GRID_SIZE: grid_size      <= cfg_data[8:0];
        CFG_BARRIER:   barrier_enable <= cfg_data[0];
        CFG_BAR_ROW:   barrier_row    <= cfg_data[7:0];
        CFG_SLIT_LOW:  slit_low       <= cfg_data[7:0];
        CFG_SLIT_HIGH: slit_high      <= cfg_data[7:0];
        default: begin
          grid_size <= grid_size;
        end
      endcase
    end
  end

  // Control: request sequencing and the result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_set) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (req_fire) begin
            if (req_type == REQ_READ && in_grid) begin
              st <= S_READ;
            end else if (req_type == REQ_SWEEP) begin
              st <= S_SWEEP;
            end
          end
        end
        S_READ: begin
          st <= S_IDLE;
        end
        S_SWEEP: begin
          if (swp_stat.done) begin
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // Result beat payload.
  always_ff @(posedge clk) begin
    if (st == S_IDLE && req_fire) begin
      height_out   <= '0;
      velocity_out <= '0;
      status       <= (req_type == REQ_WRITE || req_type == REQ_READ) && !in_grid;
    end else if (st == S_READ) begin
      height_out   <= to_port(h_rdata);
      velocity_out <= to_port(v_rdata);
      status       <= 1'b0;
    end else if (sweeping && swp_stat.done) begin
      height_out   <= '0;
      velocity_out <= '0;
      status       <= 1'b0;
    end
  end

  `ASSERT_IMPL(a_no_accept_in_sweep, st == S_SWEEP, req_stall, "request taken during sweep")
  `ASSERT_IMPL(a_done_in_sweep, swp_stat.done, st == S_SWEEP, "sweep finished unexpectedly")
  `ASSERT_NEXT(a_read_answers, st == S_READ, rsp_valid, "read produced no result beat")

endmodule

>>> tb/damped_wave_grid_sweep_unit_test.sv
`timescale 1ns / 100ps

module damped_wave_grid_sweep_unit_test;
  import dwgs_pkg::*;

  localparam int GRID_MAX = 256;
  localparam int GRID_CELLS = GRID_MAX * GRID_MAX;
  // Largest grid that random phases fill completely and sweep.
  localparam int SWEEP_MAX = 10;
  localparam int STALL_LIMIT = 5000;
  localparam longint VAL_MAX = 2147483647;
  localparam longint VAL_MIN = -VAL_MAX - 1;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [2:0] CFG_SPARE = 3'd7;

  typedef struct packed {
    logic [31:0] height;
    logic [31:0] velocity;
    logic        status;
  } cell_reply_t;

  logic               clk;
  logic               rst;
  logic               req_valid;
  logic               req_stall;
  logic [1:0]         req_type;
  logic [7:0]         row;
  logic [7:0]         col;
  logic signed [31:0] height_in;
  logic signed [31:0] velocity_in;
  logic               rsp_valid;
  logic               rsp_stall;
  logic signed [31:0] height_out;
  logic signed [31:0] velocity_out;
  logic               status;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;

  // Grid model and its copy of the registers.
  int          grid_height [GRID_CELLS];
  int          grid_velocity [GRID_CELLS];
  bit          cell_written [GRID_CELLS];
  int          written_cells [$];
  sweep_cfg_t  model_knobs;
  logic [8:0]  model_grid;
  cell_reply_t pending_replies [$];

  bit req_quiet;
  bit rsp_quiet;
  int error_count;
  int requests_sent;
  int useful_requests;
  int sweep_count;
  int read_count;
  int out_of_range_count;
  int replies_checked;
  int settings_applied;

  damped_wave_grid_sweep_unit u_dut (
    .clk,
    .rst,
    .req_valid,
    .req_stall,
    .req_type,
    .row,
    .col,
    .height_in,
    .velocity_in,
    .rsp_valid,
    .rsp_stall,
    .height_out,
    .velocity_out,
    .status,
    .cfg_valid,
    .cfg_ready,
    .cfg_index,
    .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int draw_wait(inout bit quiet);
    if ($urandom_range(0, 15) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic int grid_in_use();
    return (model_grid > GRID_MAX) ? GRID_MAX : int'(model_grid);
  endfunction

  function automatic longint clamp32(longint x);
    if (x > VAL_MAX) return VAL_MAX;
    if (x < VAL_MIN) return VAL_MIN;
    return x;
  endfunction

  // Product with a Q0.16 gain, rounded toward minus infinity.
  function automatic longint scale_q16(longint a, int g);
    return (a * g) >>> 16;
  endfunction

  function automatic void sweep_grid_model();
    int n;
    int k;
    longint h;
    longint nsum;
    longint v;
    n = grid_in_use();
    if (n < 3) return;
    for (int y = 1; y < n - 1; y++) begin
      for (int x = 1; x < n - 1; x++) begin
        k = y * GRID_MAX + x;
        h = grid_height[k];
        nsum = grid_height[k - 1];
        nsum += grid_height[k + 1];
        nsum += grid_height[k - GRID_MAX];
        nsum += grid_height[k + GRID_MAX];
        v = clamp32(grid_velocity[k] + scale_q16((nsum >>> 2) - h, model_knobs.coupling_gain));
        v = clamp32(scale_q16(v, model_knobs.damping_gain));
        grid_velocity[k] = int'(v);
        if (!(model_knobs.barrier_enable && y == model_knobs.barrier_row &&
              (x < model_knobs.slit_low || x > model_knobs.slit_high)))
          grid_height[k] = int'(clamp32(h + v));
      end
    end
  endfunction

  // Updates the grid model for one accepted request and queues the reply it must give.
  function automatic void apply_request(logic [1:0] kind, logic [7:0] r, logic [7:0] c,
                                        logic [31:0] h, logic [31:0] v);
    cell_reply_t reply;
    bit in_grid;
    int n;
    reply = '0;
    n = grid_in_use();
    in_grid = r < n && c < n;
    useful_requests++;
    case (kind)
      REQ_WRITE, REQ_READ: begin
        if (!in_grid) begin
          reply.status = 1'b1;
          out_of_range_count++;
          if (kind == REQ_WRITE) useful_requests--;
        end else if (kind == REQ_WRITE) begin
          grid_height[{r, c}] = h;
          grid_velocity[{r, c}] = v;
          if (!cell_written[{r, c}]) begin
            cell_written[{r, c}] = 1'b1;
            written_cells.push_back({r, c});
          end
        end else begin
          reply.height = grid_height[{r, c}];
          reply.velocity = grid_velocity[{r, c}];
          read_count++;
        end
      end
      REQ_SWEEP: begin
        sweep_grid_model();
        sweep_count++;
      end
      default: useful_requests--;
    endcase
    pending_replies.push_back(reply);
  endfunction

  task automatic send_request(logic [1:0] kind, logic [7:0] r, logic [7:0] c,
                              logic [31:0] h, logic [31:0] v);
    int gap;
    gap = draw_wait(req_quiet);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_type <= kind;
    row <= r;
    col <= c;
    height_in <= h;
    velocity_in <= v;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    apply_request(kind, r, c, h, v);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic write_register(logic [2:0] index, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      CFG_COUPLING:  model_knobs.coupling_gain = data;
      CFG_DAMPING:   model_knobs.damping_gain = data;
      CFG_GRID_SIZE: model_grid = data[8:0];
      CFG_BARRIER:   model_knobs.barrier_enable = data[0];
      CFG_BAR_ROW:   model_knobs.barrier_row = data[7:0];
      CFG_SLIT_LOW:  model_knobs.slit_low = data[7:0];
      CFG_SLIT_HIGH: model_knobs.slit_high = data[7:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Bits above each register's width carry noise; the block must drop them.
  task automatic apply_settings(sweep_cfg_t s, logic [8:0] g, bit spare);
    write_register(CFG_COUPLING, s.coupling_gain);
    write_register(CFG_DAMPING, s.damping_gain);
    write_register(CFG_GRID_SIZE, {7'($urandom), g});
    write_register(CFG_BARRIER, {15'($urandom), s.barrier_enable});
    write_register(CFG_BAR_ROW, {8'($urandom), s.barrier_row});
    write_register(CFG_SLIT_LOW, {8'($urandom), s.slit_low});
    write_register(CFG_SLIT_HIGH, {8'($urandom), s.slit_high});
    if (spare) write_register(CFG_SPARE, 16'($urandom));
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [31:0] draw_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    endcase
  endfunction

  function automatic logic [15:0] draw_gain();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [8:0] draw_grid_size();
    case ($urandom_range(0, 19))
      0, 1: return 9'($urandom_range(0, 2));
      2, 3: return 9'($urandom_range(200, 511));
      4: return 9'($urandom_range(8, SWEEP_MAX));
      default: return 9'($urandom_range(3, 7));
    endcase
  endfunction

  function automatic sweep_cfg_t draw_knobs(int n);
    sweep_cfg_t s;
    int span;
    span = (n > SWEEP_MAX) ? SWEEP_MAX : n;
    s.coupling_gain = draw_gain();
    s.damping_gain = draw_gain();
    s.barrier_enable = 1'($urandom);
    s.barrier_row = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, span));
    s.slit_low = ($urandom_range(0, 5) == 0) ? 8'hFF : 8'($urandom_range(0, span));
    s.slit_high = ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom_range(0, span));
    return s;
  endfunction

  task automatic fill_unwritten(int n);
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        if (!cell_written[r * GRID_MAX + c])
          send_request(REQ_WRITE, 8'(r), 8'(c), draw_value(), draw_value());
  endtask

  // Except in the out-of-grid branch, reads only touch written cells; an unwritten pick
  // falls back to a known cell, which may then lie outside the grid and answer status 1.
  task automatic random_request(int n);
    int pick;
    int k;
    logic [7:0] r;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    r = (n > 0) ? 8'($urandom_range(0, n - 1)) : 8'($urandom);
    c = (n > 0) ? 8'($urandom_range(0, n - 1)) : 8'($urandom);
    if (pick < 18 && n <= SWEEP_MAX) begin
      send_request(REQ_SWEEP, 8'($urandom), 8'($urandom), $urandom, $urandom);
    end else if (pick < 23) begin
      send_request(REQ_UNUSED, 8'($urandom), 8'($urandom), $urandom, $urandom);
    end else if (pick < 35 && n < GRID_MAX) begin
      if ($urandom_range(0, 1) == 1) r = 8'($urandom_range(n, 255));
      else c = 8'($urandom_range(n, 255));
      send_request(($urandom_range(0, 1) == 1) ? REQ_READ : REQ_WRITE, r, c,
                   draw_value(), draw_value());
    end else if (pick < 65) begin
      if (!cell_written[{r, c}]) begin
        k = written_cells[$urandom_range(0, written_cells.size() - 1)];
        r = 8'(k >> 8);
        c = 8'(k);
      end
      send_request(REQ_READ, r, c, $urandom, $urandom);
    end else begin
      send_request(REQ_WRITE, r, c, draw_value(), draw_value());
    end
  endtask

  task automatic compare_field(string label, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      error_count++;
    end
  endtask

  task automatic check_reply();
    cell_reply_t want;
    replies_checked++;
    if (pending_replies.size() == 0) begin
      $display("%0t: unexpected beat, expected none, actual height %h velocity %h status %b",
               $time, height_out, velocity_out, status);
      error_count++;
    end else begin
      want = pending_replies.pop_front();
      compare_field("height_out", want.height, height_out);
      compare_field("velocity_out", want.velocity, velocity_out);
      compare_field("status", 32'(want.status), 32'(status));
    end
  endtask

  task automatic test_default_registers();
    send_request(REQ_WRITE, 8'd0, 8'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(REQ_WRITE, 8'hFF, 8'hFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(REQ_READ, 8'd0, 8'd0, $urandom, $urandom);
    send_request(REQ_READ, 8'hFF, 8'hFF, $urandom, $urandom);
    send_request(REQ_UNUSED, 8'($urandom), 8'($urandom), $urandom, $urandom);
  endtask

  task automatic test_grid_bounds();
    sweep_cfg_t s;
    s = model_knobs;
    wait_idle();
    apply_settings(s, 9'd5, 1'b1);
    send_request(REQ_WRITE, 8'd5, 8'd2, 32'h1234_5678, 32'h8765_4321);
    send_request(REQ_READ, 8'd2, 8'd5, $urandom, $urandom);
    send_request(REQ_READ, 8'hFF, 8'd0, $urandom, $urandom);
    // A grid below three cells has no interior, so the sweep must leave everything alone.
    wait_idle();
    apply_settings(s, 9'd0, 1'b0);
    send_request(REQ_SWEEP, 8'($urandom), 8'($urandom), $urandom, $urandom);
    send_request(REQ_READ, 8'd0, 8'd0, $urandom, $urandom);
    wait_idle();
    apply_settings(s, 9'd511, 1'b0);
    send_request(REQ_READ, 8'hFF, 8'hFF, $urandom, $urandom);
  endtask

  task automatic test_small_grid_sweep();
    sweep_cfg_t s;
    bit center;
    s = model_knobs;
    s.coupling_gain = 16'hFFFF;
    s.damping_gain = 16'hFFFF;
    s.barrier_enable = 1'b0;
    wait_idle();
    apply_settings(s, 9'd3, 1'b0);
    // Values near full scale drive both sums into saturation.
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        center = (r == 1 && c == 1);
        send_request(REQ_WRITE, 8'(r), 8'(c),
                     center ? 32'h7FFF_FF00 : 32'h7FFF_FFFF - 32'(c),
                     center ? 32'h7FFF_FFFF : 32'h8000_0000 + 32'(r));
      end
    end
    send_request(REQ_SWEEP, 8'd0, 8'd0, 32'd0, 32'd0);
    send_request(REQ_READ, 8'd1, 8'd1, 32'd0, 32'd0);
    // An empty slit keeps the whole barrier row frozen.
    s.barrier_enable = 1'b1;
    s.barrier_row = 8'd1;
    s.slit_low = 8'd2;
    s.slit_high = 8'd1;
    s.coupling_gain = 16'h8000;
    wait_idle();
    apply_settings(s, 9'd3, 1'b0);
    send_request(REQ_WRITE, 8'd1, 8'd1, 32'd0, 32'h0001_0000);
    send_request(REQ_SWEEP, 8'd0, 8'd0, 32'd0, 32'd0);
    send_request(REQ_READ, 8'd1, 8'd1, 32'd0, 32'd0);
    s.slit_low = 8'd0;
    s.slit_high = 8'hFF;
    wait_idle();
    apply_settings(s, 9'd3, 1'b0);
    send_request(REQ_SWEEP, 8'd0, 8'd0, 32'd0, 32'd0);
    send_request(REQ_READ, 8'd1, 8'd1, 32'd0, 32'd0);
  endtask

  task automatic test_random_traffic();
    sweep_cfg_t s;
    logic [8:0] g;
    int n;
    int first;
    first = useful_requests;
    while (useful_requests - first < 100) begin
      g = draw_grid_size();
      n = (g > GRID_MAX) ? GRID_MAX : int'(g);
      s = draw_knobs(n);
      wait_idle();
      apply_settings(s, g, $urandom_range(0, 3) == 0);
      if (n >= 3 && n <= SWEEP_MAX) fill_unwritten(n);
      repeat ($urandom_range(8, 20)) random_request(n);
    end
  endtask

  initial begin : reply_side
    int hold;
    hold = 0;
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        check_reply();
        hold = draw_wait(rsp_quiet);
      end
      @(negedge clk);
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        hold--;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req_type = REQ_WRITE;
    row = '0;
    col = '0;
    height_in = '0;
    velocity_in = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_COUPLING;
    cfg_data = '0;
    model_knobs.coupling_gain = 16'd13107;
    model_knobs.damping_gain = 16'd59710;
    model_knobs.barrier_enable = 1'b1;
    model_knobs.barrier_row = 8'd100;
    model_knobs.slit_low = 8'd100;
    model_knobs.slit_high = 8'd110;
    model_grid = 9'd256;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_default_registers();
    test_grid_bounds();
    test_small_grid_sweep();
    test_random_traffic();

    wait_idle();
    repeat (8) @(negedge clk);
    $display("Covered %0d requests: %0d sweeps, %0d cell reads, %0d out-of-grid accesses.",
             requests_sent, sweep_count, read_count, out_of_range_count);
    $display("Checked %0d results across %0d register settings, %0d cells written.",
             replies_checked, settings_applied, written_cells.size());
    if (error_count == 0 && pending_replies.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
